[sv/dad_pkg.sv]
// dad_pkg: shared types, constants and the month-length table for the
// Gregorian date add/subtract block. No dependencies.
`default_nettype none

package dad_pkg;

    localparam int OFFSET_BITS_DEF = 16;
    localparam int YEAR_MAX_DEF    = 9999;

    localparam logic       OP_ADD = 1'b0;
    localparam logic       OP_SUB = 1'b1;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    localparam logic [4:0] FEB_LEAP_LEN = 5'd29;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    typedef struct packed {
        logic        operation;
        logic [4:0]  in_day;
        logic [3:0]  in_month;
        logic [13:0] in_year;
        logic [15:0] offset_days;
    } req_beat_t;

    typedef struct packed {
        logic [4:0]  out_day;
        logic [3:0]  out_month;
        logic [13:0] out_year;
        logic        range_error;
    } rsp_beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SPLIT,
        ST_LOAD,
        ST_STEP,
        ST_FINISH
    } dad_state_t;

    typedef struct packed {
        logic load_in;
        logic split;
        logic init;
        logic step;
        logic emit;
    } dad_cmd_t;

    typedef struct packed {
        logic settled;
        logic out_busy;
    } dad_sts_t;

    // month is 1..12 here; leap selects the long February
    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month == MONTH_FEB && leap)
            month_len = FEB_LEAP_LEN;
        else if (idx < 4'd12)
            month_len = MONTH_LEN[idx];
        else
            month_len = MONTH_LEN[0];
    endfunction

endpackage

`default_nettype wire

[sv/date_add_subtract_days.sv]
// date_add_subtract_days: top level of the Gregorian date add/subtract block.
// Depends on dad_pkg, dad_ctrl and dad_dpath.
//
// Adds or subtracts a day count to a Gregorian date and returns the normalised
// date, or the input date with range_error set when the input month or year is
// out of range, the input day is zero, or the result year leaves 1..YEAR_MAX; a
// day past the end of its month is normalised. One beat is worked at a time,
// one month step per cycle through the single step unit. The result
// sits in an output register, so the next beat is taken while an earlier
// result still waits.
`default_nettype none

module date_add_subtract_days #(
    parameter int OFFSET_BITS = dad_pkg::OFFSET_BITS_DEF,
    parameter int YEAR_MAX    = dad_pkg::YEAR_MAX_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  dad_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output dad_pkg::rsp_beat_t rsp
);
    import dad_pkg::*;

    dad_cmd_t cmd;
    dad_sts_t sts;

    dad_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    dad_dpath #(
        .OFFSET_BITS (OFFSET_BITS),
        .YEAR_MAX    (YEAR_MAX)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .cmd       (cmd),
        .sts       (sts)
    );

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while a beat is in progress");

    a_month_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.range_error) |->
            (rsp.out_month != 4'd0 && rsp.out_month <= MONTH_DEC && rsp.out_day != 5'd0))
        else $error("normalised date out of range");

    a_year_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp.range_error) |->
            (rsp.out_year != 14'd0 && 32'(rsp.out_year) <= 32'(YEAR_MAX)))
        else $error("normalised year out of range");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(rsp_valid && !rsp_ready))
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

[sv/dad_ctrl.sv]
// dad_ctrl: sequencing state machine for the date add/subtract block.
// Depends on dad_pkg; drives commands into dad_dpath.
`default_nettype none

module dad_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  dad_pkg::dad_sts_t sts,
    output dad_pkg::dad_cmd_t cmd
);
    import dad_pkg::*;

    dad_state_t state_reg;
    dad_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                    state_next = ST_SPLIT;
            end
            ST_SPLIT:  state_next = ST_LOAD;
            ST_LOAD:   state_next = ST_STEP;
            ST_STEP:
            begin
                if (sts.settled)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (!sts.out_busy)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready   = (state_reg == ST_IDLE);
        cmd.load_in = (state_reg == ST_IDLE) && req_valid;
        cmd.split   = (state_reg == ST_SPLIT);
        cmd.init    = (state_reg == ST_LOAD);
        cmd.step    = (state_reg == ST_STEP) && !sts.settled;
        cmd.emit    = (state_reg == ST_FINISH) && !sts.out_busy;
    end

endmodule

`default_nettype wire

[sv/dad_dpath.sv]
// dad_dpath: date registers, one-month step unit and output register.
// Depends on dad_pkg; commanded by dad_ctrl.
`default_nettype none

module dad_dpath #(
    parameter int OFFSET_BITS = dad_pkg::OFFSET_BITS_DEF,
    parameter int YEAR_MAX    = dad_pkg::YEAR_MAX_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  dad_pkg::req_beat_t req,
    input  logic              rsp_ready,
    output logic              rsp_valid,
    output dad_pkg::rsp_beat_t rsp,
    input  dad_pkg::dad_cmd_t cmd,
    output dad_pkg::dad_sts_t sts
);
    import dad_pkg::*;

    localparam int OW     = (OFFSET_BITS < 16) ? OFFSET_BITS : 16;
    localparam int DW     = OW + 2;
    localparam int YW     = $clog2(YEAR_MAX + 1);
    localparam int CW_RAW = $clog2(YEAR_MAX / 100 + 1);
    localparam int CW     = (CW_RAW < 2) ? 2 : CW_RAW;
    localparam logic [12:0] RECIP_100 = 13'd5243;   // floor(y/100) = y*5243 >> 19
    localparam int          RECIP_SH  = 19;
    localparam logic [6:0]  YY_LAST   = 7'd99;
    localparam logic [YW-1:0] YEAR_TOP = YW'(YEAR_MAX);

    req_beat_t          in_reg;
    logic [26:0]        prod_reg;
    logic signed [DW-1:0] d_reg, d_next;
    logic [3:0]         m_reg, m_next;
    logic [YW-1:0]      y_reg, y_next;
    logic [6:0]         yy_reg, yy_next;
    logic [CW-1:0]      c_reg, c_next;
    logic               err_reg, err_next;
    rsp_beat_t          rsp_reg;
    logic               rsp_valid_reg;

    // initial split of the year into century and year-of-century
    logic [13:0]        q14;
    logic [13:0]        rem14;
    logic               in_bad;
    logic signed [DW-1:0] d0_s, off_s, d_init;

    always_comb
    begin
        q14    = 14'(prod_reg[26:RECIP_SH]);
        rem14  = in_reg.in_year - q14 * 14'd100;
        in_bad = (in_reg.in_month == 4'd0) || (in_reg.in_month > MONTH_DEC)
              || (in_reg.in_year == 14'd0) || (32'(in_reg.in_year) > 32'(YEAR_MAX))
              || (in_reg.in_day == 5'd0);
        d0_s   = signed'(DW'(in_reg.in_day));
        off_s  = signed'(DW'(in_reg.offset_days[OW-1:0]));
        d_init = (in_reg.operation == OP_SUB) ? (d0_s - off_s) : (d0_s + off_s);
    end

    // one month step
    logic               back;
    logic               leap_cur, leap_prev;
    logic [4:0]         dim_cur, dim_prev;
    logic [3:0]         m_prev;
    logic [YW-1:0]      y_prev;
    logic [6:0]         yy_prev;
    logic [CW-1:0]      c_prev;
    logic               wrap_back;
    logic signed [DW-1:0] dim_cur_s, dim_prev_s;
    logic               over;

    always_comb
    begin
        back      = d_reg[DW-1] || (d_reg == '0);
        wrap_back = (m_reg == MONTH_JAN);
        m_prev    = wrap_back ? MONTH_DEC : (m_reg - 4'd1);
        y_prev    = wrap_back ? (y_reg - YW'(1)) : y_reg;
        if (wrap_back && yy_reg == 7'd0)
        begin
            yy_prev = YY_LAST;
            c_prev  = c_reg - CW'(1);
        end
        else if (wrap_back)
        begin
            yy_prev = yy_reg - 7'd1;
            c_prev  = c_reg;
        end
        else
        begin
            yy_prev = yy_reg;
            c_prev  = c_reg;
        end
        leap_cur   = (yy_reg != 7'd0) ? (yy_reg[1:0] == 2'b00) : (c_reg[1:0] == 2'b00);
        leap_prev  = (yy_prev != 7'd0) ? (yy_prev[1:0] == 2'b00) : (c_prev[1:0] == 2'b00);
        dim_cur    = month_len(m_reg, leap_cur);
        dim_prev   = month_len(m_prev, leap_prev);
        dim_cur_s  = signed'(DW'(dim_cur));
        dim_prev_s = signed'(DW'(dim_prev));
        over       = !back && (d_reg > dim_cur_s);
    end

    always_comb
    begin
        d_next   = d_reg;
        m_next   = m_reg;
        y_next   = y_reg;
        yy_next  = yy_reg;
        c_next   = c_reg;
        err_next = err_reg;
        priority if (cmd.init)
        begin
            d_next   = d_init;
            m_next   = in_reg.in_month;
            y_next   = YW'(in_reg.in_year);
            yy_next  = rem14[6:0];
            c_next   = CW'(q14);
            err_next = in_bad;
        end
        else if (cmd.step && back)
        begin
            if (wrap_back && y_reg == YW'(1))
                err_next = 1'b1;
            else
            begin
                m_next  = m_prev;
                y_next  = y_prev;
                yy_next = yy_prev;
                c_next  = c_prev;
                d_next  = d_reg + dim_prev_s;
            end
        end
        else if (cmd.step && over)
        begin
            if (m_reg == MONTH_DEC && y_reg == YEAR_TOP)
                err_next = 1'b1;
            else
            begin
                d_next = d_reg - dim_cur_s;
                if (m_reg == MONTH_DEC)
                begin
                    m_next = MONTH_JAN;
                    y_next = y_reg + YW'(1);
                    if (yy_reg == YY_LAST)
                    begin
                        yy_next = 7'd0;
                        c_next  = c_reg + CW'(1);
                    end
                    else
                        yy_next = yy_reg + 7'd1;
                end
                else
                    m_next = m_reg + 4'd1;
            end
        end
        else
            err_next = err_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= req;
        if (cmd.split)
            prod_reg <= 27'(in_reg.in_year) * 27'(RECIP_100);
        d_reg   <= d_next;
        m_reg   <= m_next;
        y_reg   <= y_next;
        yy_reg  <= yy_next;
        c_reg   <= c_next;
        err_reg <= err_next;
        if (cmd.emit)
        begin
            if (err_reg)
            begin
                rsp_reg.out_day     <= in_reg.in_day;
                rsp_reg.out_month   <= in_reg.in_month;
                rsp_reg.out_year    <= in_reg.in_year;
                rsp_reg.range_error <= 1'b1;
            end
            else
            begin
                rsp_reg.out_day     <= d_reg[4:0];
                rsp_reg.out_month   <= m_reg;
                rsp_reg.out_year    <= 14'(y_reg);
                rsp_reg.range_error <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_valid_reg <= 1'b0;
        else if (cmd.emit)
            rsp_valid_reg <= 1'b1;
        else if (rsp_ready)
            rsp_valid_reg <= 1'b0;
    end

    assign sts.settled  = err_reg || (!back && !over);
    assign sts.out_busy = rsp_valid_reg && !rsp_ready;
    assign rsp_valid    = rsp_valid_reg;
    assign rsp          = rsp_reg;

endmodule

`default_nettype wire

[bench/tb_date_add_subtract_days.sv]
// tb_date_add_subtract_days: self-checking bench for the date add/subtract block.
// Drives request beats, predicts each resulting date and checks response beats in order.
// Depends on dad_pkg and date_add_subtract_days.
`timescale 1ns / 1ps

module tb_date_add_subtract_days;
    import dad_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 2200;
    localparam int RANDOM_PER_PHASE = 84;

    class date_scoreboard;
        rsp_beat_t expected_dates[$];
        int mismatches = 0;

        function int month_days(int m, int y);
            bit leap;
            leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
            if (m == int'(MONTH_FEB))
                return leap ? 29 : 28;
            if (m == 4 || m == 6 || m == 9 || m == 11)
                return 30;
            return 31;
        endfunction

        function rsp_beat_t shift_date(req_beat_t b);
            rsp_beat_t r;
            int d;
            int m;
            int y;
            bit bad;
            m = int'(b.in_month);
            y = int'(b.in_year);
            d = int'(b.in_day);
            bad = (b.in_month < MONTH_JAN) || (b.in_month > MONTH_DEC) || (b.in_year == 14'd0)
                || (int'(b.in_year) > YEAR_MAX_DEF) || (b.in_day == 5'd0);
            if (!bad)
            begin
                if (b.operation == OP_SUB)
                    d = d - int'(b.offset_days);
                else
                    d = d + int'(b.offset_days);
                while (!bad && d <= 0)
                begin
                    if (m == int'(MONTH_JAN))
                    begin
                        m = int'(MONTH_DEC);
                        y--;
                        if (y < 1)
                            bad = 1'b1;
                    end
                    else
                        m--;
                    if (!bad)
                        d += month_days(m, y);
                end
                while (!bad && d > month_days(m, y))
                begin
                    d -= month_days(m, y);
                    if (m == int'(MONTH_DEC))
                    begin
                        m = int'(MONTH_JAN);
                        y++;
                        if (y > YEAR_MAX_DEF)
                            bad = 1'b1;
                    end
                    else
                        m++;
                end
            end
            if (bad)
            begin
                r.out_day = b.in_day;
                r.out_month = b.in_month;
                r.out_year = b.in_year;
                r.range_error = 1'b1;
            end
            else
            begin
                r.out_day = d[4:0];
                r.out_month = m[3:0];
                r.out_year = y[13:0];
                r.range_error = 1'b0;
            end
            return r;
        endfunction

        function void note_request(req_beat_t b);
            expected_dates.push_back(shift_date(b));
        endfunction

        function void check_result(rsp_beat_t got);
            rsp_beat_t want;
            if (expected_dates.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %0d/%0d/%0d err=%0b",
                        got.out_day, got.out_month, got.out_year, got.range_error);
                return;
            end
            want = expected_dates.pop_front();
            if (got.out_day !== want.out_day || got.out_month !== want.out_month
                || got.out_year !== want.out_year || got.range_error !== want.range_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %0d/%0d/%0d err=%0b, got %0d/%0d/%0d err=%0b",
                        want.out_day, want.out_month, want.out_year, want.range_error,
                        got.out_day, got.out_month, got.out_year, got.range_error);
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_beat_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_beat_t rsp;

    int send_idle = 33;
    int rcv_idle = 79;
    int stall_cycles = 0;
    date_scoreboard sb;

    date_add_subtract_days uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp(rsp)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("FAIL date_add_subtract_days");
                $finish;
            end
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            rsp_ready <= (int'($urandom_range(99)) >= rcv_idle);
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
        end
    end

    task automatic send_beat(input req_beat_t b);
        if (int'($urandom_range(99)) < send_idle)
        begin
            req_valid <= 1'b0;
            do
                @(posedge clk);
            while (int'($urandom_range(99)) < send_idle);
        end
        req_valid <= 1'b1;
        req <= b;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.note_request(b);
    endtask

    task automatic send_date(input logic op, input int d, input int m, input int y,
                             input int off);
        req_beat_t b;
        b.operation = op;
        b.in_day = d[4:0];
        b.in_month = m[3:0];
        b.in_year = y[13:0];
        b.offset_days = off[15:0];
        send_beat(b);
    endtask

    function automatic req_beat_t random_request();
        req_beat_t b;
        int pick;
        b.operation = 1'($urandom_range(1));
        pick = int'($urandom_range(99));
        if (pick < 15)
        begin
            b.in_day = 5'($urandom);
            b.in_month = 4'($urandom);
            b.in_year = 14'($urandom);
        end
        else
        begin
            b.in_day = 5'($urandom_range(31, 1));
            b.in_month = 4'($urandom_range(12, 1));
            if (pick < 25)
                b.in_year = 14'($urandom_range(3, 1));
            else if (pick < 35)
                b.in_year = 14'($urandom_range(YEAR_MAX_DEF, YEAR_MAX_DEF - 2));
            else
                b.in_year = 14'($urandom_range(YEAR_MAX_DEF, 1));
        end
        pick = int'($urandom_range(99));
        if (pick < 70)
            b.offset_days = 16'($urandom_range(400));
        else if (pick < 90)
            b.offset_days = 16'($urandom_range(4000));
        else if (pick < 93)
            b.offset_days = (pick < 92) ? 16'h0000 : 16'hFFFF;
        else
            b.offset_days = 16'($urandom_range(65535));
        return b;
    endfunction

    initial
    begin
        sb = new();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // boundaries of the calendar range
        send_date(OP_ADD, 1, 1, 1, 0);
        send_date(OP_SUB, 1, 1, 1, 1);
        send_date(OP_ADD, 31, 12, 9999, 1);
        send_date(OP_SUB, 31, 12, 9999, 0);
        // leap year rules
        send_date(OP_ADD, 28, 2, 2024, 1);
        send_date(OP_ADD, 28, 2, 2023, 1);
        send_date(OP_ADD, 28, 2, 1900, 1);
        send_date(OP_ADD, 28, 2, 2000, 1);
        send_date(OP_SUB, 1, 3, 2024, 1);
        send_date(OP_SUB, 15, 3, 2023, 31);
        send_date(OP_ADD, 31, 1, 2021, 30);
        // malformed inputs
        send_date(OP_ADD, 10, 0, 2000, 5);
        send_date(OP_ADD, 10, 13, 2000, 5);
        send_date(OP_SUB, 31, 15, 16383, 65535);
        send_date(OP_ADD, 10, 6, 0, 5);
        send_date(OP_ADD, 10, 6, 10000, 5);
        send_date(OP_SUB, 0, 6, 2000, 5);
        // day past the end of its month
        send_date(OP_ADD, 31, 2, 2023, 0);
        send_date(OP_SUB, 31, 4, 2023, 0);
        // widest offsets
        send_date(OP_ADD, 1, 1, 2000, 65535);
        send_date(OP_SUB, 31, 12, 9999, 65535);
        send_date(OP_SUB, 1, 1, 100, 65535);

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 33 : (ph == 1) ? 79 : 0;
            rcv_idle = (ph == 0) ? 79 : (ph == 1) ? 33 : 0;
            for (int n = 0; n < RANDOM_PER_PHASE; n++)
                send_beat(random_request());
        end
        req_valid <= 1'b0;

        while (sb.expected_dates.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.mismatches == 0 && sb.expected_dates.size() == 0)
            $display("PASS date_add_subtract_days");
        else
            $display("FAIL date_add_subtract_days");
        $finish;
    end

endmodule
